>>> hw/rtl/positional_ordered_list_assert.svh
// assertion macros used by the checker file
`ifndef POSITIONAL_ORDERED_LIST_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ASSERT_SVH

// clocked assertion, switched off while reset is held
`define POL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form built on the macro above
`define POL_ASSERT_IMP(label, pre, post, msg) \
    `POL_ASSERT(label, (pre) |-> (post), msg)

`endif

>>> hw/rtl/pol_pkg.sv
// package: codes, field widths and cell control type for the ordered list
package pol_pkg;

    // default bound on stored values
    localparam int CAPACITY_DEF = 64;

    // field widths
    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int INDEX_W = 7;
    localparam int COUNT_W = 7;

    // stream widths
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 80;

    // commands
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT_AT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_REMOVE_VAL = 3'd6;
    localparam logic [CMD_W-1:0] CMD_FIND       = 3'd7;

    // result status
    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // index reported when nothing was found
    localparam logic [INDEX_W-1:0] INDEX_NONE = 7'h7f;

    // cell operations
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_REMOVE = 2'd2;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic [1:0] op;
        logic       compare;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/positional_ordered_list.sv
// top level of the bounded positional ordered list
// An ordered list of up to CAPACITY 32-bit values held in a row of cells, one value per
// cell with the head in cell zero. Each command is handled as follows: in the cycle it is
// accepted every cell compares its value with item_value, in the next cycle the command is
// resolved from the match bits (first match by lowest-bit isolation) and the cells from
// the target position on shift one place towards the tail for an insert or towards the
// head for a removal; the result beat is loaded in the following cycle, which also accepts
// the next command, so a new command is only taken once the previous one has gone through
// the compare and the shift in the cell row. The result beat carries status, found index,
// count and the head and tail values after the command. A stalled result blocks new
// commands only once the next one needs the output register.
module positional_ordered_list #(
    parameter int CAPACITY = pol_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command
    input  logic [pol_pkg::CMD_W-1:0]     s_tuser,
    // position [6:0], item_value [38:7], zero pad [39]
    input  logic [pol_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [1:0], found_index [8:2], entry_count [15:9], head_value [47:16],
    // tail_value [79:48]
    output logic [pol_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int CMP_W = (CNT_W > pol_pkg::POS_W) ? CNT_W : pol_pkg::POS_W;
    localparam int VAL_W = pol_pkg::VAL_W;

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_APPLY  = 2'd1;
    localparam logic [1:0] S_REPORT = 2'd2;

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic [pol_pkg::CMD_W-1:0]     cmd_reg;
    logic [pol_pkg::POS_W-1:0]     pos_reg;
    logic [VAL_W-1:0]              val_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic [pol_pkg::STAT_W-1:0]    status_reg;
    logic [pol_pkg::STAT_W-1:0]    status_next;
    logic [pol_pkg::INDEX_W-1:0]   found_reg;
    logic [pol_pkg::INDEX_W-1:0]   found_next;
    logic                          out_valid_reg;
    logic [pol_pkg::M_DATA_W-1:0]  out_data_reg;

    logic                          in_fire;
    logic                          out_free;
    logic                          report_load;
    logic [VAL_W-1:0]              in_value;

    pol_pkg::cell_ctrl_t           ctrl;
    logic [1:0]                    apply_op;
    logic [IDX_W-1:0]              apply_where;
    logic [VAL_W-1:0]              cell_item;

    logic [VAL_W-1:0]              cell_val  [CAPACITY];
    logic [VAL_W-1:0]              cell_tail [CAPACITY];
    logic [CAPACITY-1:0]           match_vec;
    logic [CAPACITY-1:0]           match_low;
    logic [IDX_W-1:0]              match_idx;
    logic                          match_any;
    logic                          is_full;
    logic                          is_empty;
    logic [VAL_W-1:0]              head_value;
    logic [VAL_W-1:0]              tail_value;

    // handshake
    assign out_free    = !out_valid_reg || m_tready;
    assign s_tready    = (state_reg == S_IDLE) || ((state_reg == S_REPORT) && out_free);
    assign in_fire     = s_tvalid && s_tready;
    assign report_load = (state_reg == S_REPORT) && out_free;
    assign in_value    = s_tdata[pol_pkg::POS_W +: VAL_W];

    // cells compare against the incoming value, insert the latched one
    assign cell_item    = (state_reg == S_APPLY) ? val_reg : in_value;
    assign ctrl.compare = in_fire;
    assign ctrl.op      = (state_reg == S_APPLY) ? apply_op : pol_pkg::CELL_HOLD;

    // row of cells
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [VAL_W-1:0] left_value;
        logic [VAL_W-1:0] right_value;

        if (k == 0)
        begin : g_first
            assign left_value = '0;
        end
        else
        begin : g_inner_l
            assign left_value = cell_val[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_inner_r
            assign right_value = cell_val[k+1];
        end

        pol_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (k)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .where       (apply_where),
            .count       (cnt_reg),
            .item        (cell_item),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_val[k]),
            .tail_part   (cell_tail[k]),
            .match       (match_vec[k])
        );
    end

    // first match: isolate the lowest set bit, then encode it
    assign match_low = match_vec & (~match_vec + CAPACITY'(1));
    assign match_any = |match_vec;

    always_comb
    begin
        match_idx = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (match_low[k])
            begin
                match_idx = match_idx | IDX_W'(k);
            end
        end
    end

    // head and tail of the current row
    assign head_value = is_empty ? '0 : cell_val[0];

    always_comb
    begin
        tail_value = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            tail_value = tail_value | cell_tail[k];
        end
    end

    assign is_full  = (cnt_reg == CNT_W'(CAPACITY));
    assign is_empty = (cnt_reg == '0);

    // command resolution
    always_comb
    begin
        apply_op    = pol_pkg::CELL_HOLD;
        apply_where = '0;
        status_next = pol_pkg::ST_DONE;
        found_next  = pol_pkg::INDEX_NONE;
        cnt_next    = cnt_reg;
        case (cmd_reg)
            pol_pkg::CMD_PUSH_FRONT,
            pol_pkg::CMD_PUSH_BACK,
            pol_pkg::CMD_INSERT_AT:
            begin
                if (is_full)
                begin
                    status_next = pol_pkg::ST_FULL;
                end
                else
                begin
                    apply_op = pol_pkg::CELL_INSERT;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cmd_reg == pol_pkg::CMD_PUSH_FRONT)
                    begin
                        apply_where = '0;
                    end
                    else if ((cmd_reg == pol_pkg::CMD_INSERT_AT) &&
                             (CMP_W'(pos_reg) < CMP_W'(cnt_reg)))
                    begin
                        apply_where = IDX_W'(pos_reg);
                    end
                    else
                    begin
                        apply_where = IDX_W'(cnt_reg);
                    end
                end
            end
            pol_pkg::CMD_REMOVE_AT:
            begin
                if (CMP_W'(pos_reg) >= CMP_W'(cnt_reg))
                begin
                    status_next = pol_pkg::ST_NONE;
                end
                else
                begin
                    apply_op    = pol_pkg::CELL_REMOVE;
                    apply_where = IDX_W'(pos_reg);
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
            end
            pol_pkg::CMD_POP_FRONT,
            pol_pkg::CMD_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = pol_pkg::ST_NONE;
                end
                else
                begin
                    apply_op = pol_pkg::CELL_REMOVE;
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cmd_reg == pol_pkg::CMD_POP_BACK)
                    begin
                        apply_where = IDX_W'(cnt_reg - CNT_W'(1));
                    end
                end
            end
            pol_pkg::CMD_REMOVE_VAL:
            begin
                if (!match_any)
                begin
                    status_next = pol_pkg::ST_NONE;
                end
                else
                begin
                    apply_op    = pol_pkg::CELL_REMOVE;
                    apply_where = match_idx;
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                // find
                if (match_any)
                begin
                    found_next = pol_pkg::INDEX_W'(match_idx);
                end
                else
                begin
                    status_next = pol_pkg::ST_NONE;
                end
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (in_fire)
                begin
                    state_next = S_APPLY;
                end
                else if (report_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_APPLY)
            begin
                cnt_reg <= cnt_next;
            end
            if (report_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= s_tuser;
            pos_reg <= s_tdata[pol_pkg::POS_W-1:0];
            val_reg <= in_value;
        end
        if (state_reg == S_APPLY)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
        end
        if (report_load)
        begin
            out_data_reg <= {tail_value, head_value, pol_pkg::COUNT_W'(cnt_reg),
                             found_reg, status_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> hw/rtl/pol_cell.sv
// one storage cell of the list row: value, neighbour shift and compare
module pol_cell #(
    parameter int CAPACITY = pol_pkg::CAPACITY_DEF,
    parameter int IDX      = 0
) (
    input  logic                                clk,
    input  pol_pkg::cell_ctrl_t                 ctrl,
    input  logic [$clog2(CAPACITY)-1:0]         where,
    input  logic [$clog2(CAPACITY+1)-1:0]       count,
    input  logic [pol_pkg::VAL_W-1:0]           item,
    input  logic [pol_pkg::VAL_W-1:0]           left_value,
    input  logic [pol_pkg::VAL_W-1:0]           right_value,
    output logic [pol_pkg::VAL_W-1:0]           value,
    output logic [pol_pkg::VAL_W-1:0]           tail_part,
    output logic                                match
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY+1);

    logic [pol_pkg::VAL_W-1:0] value_reg;
    logic [pol_pkg::VAL_W-1:0] value_next;
    logic                      match_reg;
    logic                      is_last;

    // next value from the shift direction
    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            pol_pkg::CELL_INSERT:
            begin
                if (IDX_W'(IDX) > where)
                begin
                    value_next = left_value;
                end
                else if (IDX_W'(IDX) == where)
                begin
                    value_next = item;
                end
            end
            pol_pkg::CELL_REMOVE:
            begin
                if (IDX_W'(IDX) >= where)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // stored value
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // occupied cell holding the searched value
    always_ff @(posedge clk)
    begin
        if (ctrl.compare)
        begin
            match_reg <= (value_reg == item) && (CNT_W'(IDX) < count);
        end
    end

    // contribution to the tail read
    assign is_last   = (count == CNT_W'(IDX + 1));
    assign tail_part = value_reg & {pol_pkg::VAL_W{is_last}};
    assign value     = value_reg;
    assign match     = match_reg;

endmodule

>>> hw/rtl/pol_checker.sv
// port checker for the ordered list, bound to the top level
`include "positional_ordered_list_assert.svh"

module pol_checker #(
    parameter int CAPACITY = pol_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [pol_pkg::M_DATA_W-1:0]  m_tdata
);

    logic [pol_pkg::STAT_W-1:0]  out_status;
    logic [pol_pkg::INDEX_W-1:0] out_found;
    logic [pol_pkg::COUNT_W-1:0] out_count;
    logic [pol_pkg::VAL_W-1:0]   out_head;
    logic [pol_pkg::VAL_W-1:0]   out_tail;
    logic                        in_beat;
    logic                        exact_count;
    logic                        stalled;
    logic                        found_hit;
    logic                        status_done;
    logic                        empty_out;
    logic                        ends_zero;

    // result beat fields
    assign out_status  = m_tdata[1:0];
    assign out_found   = m_tdata[8:2];
    assign out_count   = m_tdata[15:9];
    assign out_head    = m_tdata[47:16];
    assign out_tail    = m_tdata[79:48];
    assign in_beat     = s_tvalid && s_tready;
    assign exact_count = (CAPACITY < 128);

    // conditions watched below
    assign stalled     = m_tvalid && !m_tready;
    assign found_hit   = m_tvalid && (out_found != pol_pkg::INDEX_NONE);
    assign status_done = (out_status == pol_pkg::ST_DONE);
    assign empty_out   = m_tvalid && exact_count && (out_count == '0);
    assign ends_zero   = (out_head == '0) && (out_tail == '0);

    // a stalled result beat stays offered
    `POL_ASSERT_IMP(a_out_hold, stalled, ##1 m_tvalid, "result beat dropped while stalled")

    // every command needs its shift step before the next one is taken
    `POL_ASSERT_IMP(a_no_back_to_back, in_beat, ##1 !s_tready, "command taken in shift cycle")

    // a found index is only reported with a done status
    `POL_ASSERT_IMP(a_found_done, found_hit, status_done, "found index with failing status")

    // an empty list shows zero head and tail
    `POL_ASSERT_IMP(a_empty_zero, empty_out, ends_zero, "empty list with nonzero head or tail")

endmodule

bind positional_ordered_list pol_checker #(
    .CAPACITY (CAPACITY)
) u_pol_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
